/* hw/rtl/assert_macros.svh */
// Assertion helper macros for the speed command framer RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a condition never holds on a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hw/rtl/msf_pkg.sv */
// Shared types and constants for the mecanum speed command framer.
// No dependencies; imported by every module of the block.
package msf_pkg;

  // Command function codes
  localparam logic [1:0] FUNC_FORWARD = 2'd0;
  localparam logic [1:0] FUNC_TURN    = 2'd1;
  localparam logic [1:0] FUNC_TWIST   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_LINEAR_GAIN   = 3'd0;
  localparam logic [2:0] CFG_ROTATION_GAIN = 3'd1;
  localparam logic [2:0] CFG_FRONT_ADDR    = 3'd2;
  localparam logic [2:0] CFG_REAR_ADDR     = 3'd3;
  localparam logic [2:0] CFG_NEGATE_MASK   = 3'd4;
  localparam logic [2:0] CFG_INVERT_ROT    = 3'd5;

  // Configuration reset values
  localparam logic [15:0] LINEAR_GAIN_RST   = 16'd1000;
  localparam logic [15:0] ROTATION_GAIN_RST = 16'd1000;
  localparam logic [7:0]  FRONT_ADDR_RST    = 8'd128;
  localparam logic [7:0]  REAR_ADDR_RST     = 8'd129;

  // Fixed point and arithmetic widths
  localparam int VEL_FRAC_BITS_DEF = 8;
  localparam int PROD_W            = 33;  // 17-bit signed velocity times 16-bit gain
  localparam int SPEED_W           = 32;

  // Packet layout
  localparam logic [7:0] CMD_SPEED_PAIR = 8'd37;
  localparam logic [6:0] CHECK_MASK     = 7'h7F;
  localparam logic [7:0] BYTE_MASK      = 8'hFF;
  localparam int PKT_LEN    = 11;
  localparam int FRAME_LEN  = 2 * PKT_LEN;
  localparam int BCNT_W     = $clog2(FRAME_LEN);
  localparam int PIDX_W     = $clog2(PKT_LEN);
  localparam logic [PIDX_W-1:0] POS_ADDR  = PIDX_W'(0);
  localparam logic [PIDX_W-1:0] POS_CMD   = PIDX_W'(1);
  localparam logic [PIDX_W-1:0] POS_SPD_A = PIDX_W'(2);
  localparam logic [PIDX_W-1:0] POS_SPD_B = PIDX_W'(6);
  localparam logic [PIDX_W-1:0] POS_CHECK = PIDX_W'(10);

  // Frame queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [15:0] linear_gain;
    logic [15:0] rotation_gain;
    logic [7:0]  front_address;
    logic [7:0]  rear_address;
    logic [3:0]  wheel_negate_mask;
    logic        invert_rotation;
  } cfg_t;

  // Four wheel speeds, low 32 bits of two's complement
  typedef struct packed {
    logic [SPEED_W-1:0] w1;
    logic [SPEED_W-1:0] w2;
    logic [SPEED_W-1:0] w3;
    logic [SPEED_W-1:0] w4;
  } frame_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_stat_t;

endpackage

/* hw/rtl/msf_front.sv */
// Front end: accepts commands, scales velocities, updates stored state
// and mixes four wheel speeds into a frame for the queue. Uses msf_pkg.
`include "assert_macros.svh"
module msf_front import msf_pkg::*; #(
  parameter int VEL_FRAC_BITS = VEL_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic signed [15:0] in_vel_forward,
  input  logic signed [15:0] in_vel_side,
  input  logic signed [15:0] in_vel_turn,
  input  cfg_t        cfg,
  input  q_stat_t     q_stat,
  output logic        push,
  output frame_t      push_data
);

  localparam int SW   = PROD_W - VEL_FRAC_BITS;
  localparam int WW   = SW + 2;
  localparam int WIDE = (WW > SPEED_W) ? WW : SPEED_W;

  // Stage A: captured operands
  logic              v_a_r, v_a_nxt;
  logic [1:0]        func_a_r;
  logic signed [15:0] f_a_r, s_a_r;
  logic signed [16:0] t_a_r, t_a_nxt;
  // Stage B: products
  logic              v_b_r;
  logic [1:0]        func_b_r;
  logic signed [PROD_W-1:0] pf_b_r, ps_b_r, pt_b_r;
  // Stage C: stored scaled velocities
  logic              v_c_r;
  logic signed [SW-1:0] scaled_f_r, scaled_s_r, scaled_t_r;
  logic signed [SW-1:0] scaled_f_nxt, scaled_s_nxt, scaled_t_nxt;

  logic [QCNT_W:0]   inflight;
  logic              accept;
  logic signed [16:0] fa17, sa17, lg17, rg17;
  logic signed [33:0] pf_full, ps_full, pt_full;
  logic signed [PROD_W-1:0] pf_sh, ps_sh, pt_sh;
  logic signed [WIDE-1:0] ef, es, et;
  logic signed [WIDE-1:0] m1, m2, m3, m4;
  logic signed [WIDE-1:0] n1, n2, n3, n4;

  // Hold input while queue plus pipeline slots are all claimed
  assign inflight = {1'b0, q_stat.count} + {{QCNT_W{1'b0}}, v_a_r}
                  + {{QCNT_W{1'b0}}, v_b_r} + {{QCNT_W{1'b0}}, v_c_r};
  assign in_stall = (inflight >= (QCNT_W + 1)'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  // Drop the unused function code at the door
  always_comb begin
    v_a_nxt = 1'b0;
    case (in_func)
      FUNC_FORWARD, FUNC_TURN, FUNC_TWIST: v_a_nxt = accept;
      default:                             v_a_nxt = 1'b0;
    endcase
    t_a_nxt = cfg.invert_rotation ? -{in_vel_turn[15], in_vel_turn}
                                  :  {in_vel_turn[15], in_vel_turn};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      v_a_r <= v_a_nxt;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
    end
  end

  // Capture operands
  always_ff @(posedge clk) begin
    if (accept) begin
      func_a_r <= in_func;
      f_a_r    <= in_vel_forward;
      s_a_r    <= in_vel_side;
      t_a_r    <= t_a_nxt;
    end
  end

  // Multiply by gains
  assign fa17    = {f_a_r[15], f_a_r};
  assign sa17    = {s_a_r[15], s_a_r};
  assign lg17    = {1'b0, cfg.linear_gain};
  assign rg17    = {1'b0, cfg.rotation_gain};
  assign pf_full = fa17 * lg17;
  assign ps_full = sa17 * lg17;
  assign pt_full = t_a_r * rg17;

  always_ff @(posedge clk) begin
    func_b_r <= func_a_r;
    pf_b_r   <= pf_full[PROD_W-1:0];
    ps_b_r   <= ps_full[PROD_W-1:0];
    pt_b_r   <= pt_full[PROD_W-1:0];
  end

  // Shift right with floor and update the selected state
  assign pf_sh = pf_b_r >>> VEL_FRAC_BITS;
  assign ps_sh = ps_b_r >>> VEL_FRAC_BITS;
  assign pt_sh = pt_b_r >>> VEL_FRAC_BITS;

  always_comb begin
    scaled_f_nxt = scaled_f_r;
    scaled_s_nxt = scaled_s_r;
    scaled_t_nxt = scaled_t_r;
    if (v_b_r) begin
      case (func_b_r)
        FUNC_FORWARD: scaled_f_nxt = pf_sh[SW-1:0];
        FUNC_TURN:    scaled_t_nxt = pt_sh[SW-1:0];
        FUNC_TWIST: begin
          scaled_f_nxt = pf_sh[SW-1:0];
          scaled_s_nxt = ps_sh[SW-1:0];
          scaled_t_nxt = pt_sh[SW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scaled_f_r <= '0;
      scaled_s_r <= '0;
      scaled_t_r <= '0;
    end else begin
      scaled_f_r <= scaled_f_nxt;
      scaled_s_r <= scaled_s_nxt;
      scaled_t_r <= scaled_t_nxt;
    end
  end

  // Mix wheel speeds from the updated state and apply the negate mask
  assign ef = {{(WIDE - SW){scaled_f_r[SW-1]}}, scaled_f_r};
  assign es = {{(WIDE - SW){scaled_s_r[SW-1]}}, scaled_s_r};
  assign et = {{(WIDE - SW){scaled_t_r[SW-1]}}, scaled_t_r};
  assign m1 = ef - es + et;
  assign m2 = ef + es - et;
  assign m3 = ef - es - et;
  assign m4 = ef + es + et;
  assign n1 = cfg.wheel_negate_mask[0] ? -m1 : m1;
  assign n2 = cfg.wheel_negate_mask[1] ? -m2 : m2;
  assign n3 = cfg.wheel_negate_mask[2] ? -m3 : m3;
  assign n4 = cfg.wheel_negate_mask[3] ? -m4 : m4;

  assign push         = v_c_r;
  assign push_data.w1 = n1[SPEED_W-1:0];
  assign push_data.w2 = n2[SPEED_W-1:0];
  assign push_data.w3 = n3[SPEED_W-1:0];
  assign push_data.w4 = n4[SPEED_W-1:0];

  // Credits must leave a free queue slot for every frame pushed
  `ASSERT_NEVER(a_front_credit, v_c_r && (q_stat.count == QCNT_W'(QUEUE_DEPTH)))

endmodule

/* hw/rtl/msf_queue.sv */
// Short frame queue that decouples the front end from the serializer.
// Register storage, combinational read of the head entry. Uses msf_pkg.
`include "assert_macros.svh"
module msf_queue import msf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  frame_t  push_data,
  input  logic    pop,
  output frame_t  pop_data,
  output q_stat_t stat
);

  frame_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write the tail entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

  `ASSERT_NEVER(a_q_overflow, push && !pop && (count_r == QCNT_W'(QUEUE_DEPTH)))
  `ASSERT_NEVER(a_q_underflow, pop && (count_r == '0))

endmodule

/* hw/rtl/msf_back.sv */
// Back end: serializes one frame into two 11-byte speed packets with
// running checksum, through an output register. Uses msf_pkg.
`include "assert_macros.svh"
module msf_back import msf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  q_stat_t    q_stat,
  input  frame_t     q_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte
);

  logic              busy_r, busy_nxt;
  logic [BCNT_W-1:0] cnt_r, cnt_nxt;
  frame_t            frame_r;
  logic [6:0]        sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        tx_byte_r, tx_byte_nxt;
  logic              last_byte_r, last_byte_nxt;

  logic              slot_free;
  logic              advance;
  logic              is_last;
  logic              rear;
  logic [BCNT_W-1:0] cnt_rear;
  logic [PIDX_W-1:0] pidx;
  logic [PIDX_W-1:0] spd_off;
  logic [SPEED_W-1:0] spd_a, spd_b, spd_sel;
  logic [7:0]        addr;
  logic [7:0]        spd_byte;
  logic [7:0]        cur_byte;
  logic              load;

  assign slot_free = !out_valid_r || !out_stall;
  assign advance   = busy_r && slot_free;
  assign is_last   = (cnt_r == BCNT_W'(FRAME_LEN - 1));

  // Locate the byte within its packet
  assign rear     = (cnt_r >= BCNT_W'(PKT_LEN));
  assign cnt_rear = cnt_r - BCNT_W'(PKT_LEN);
  assign pidx     = rear ? cnt_rear[PIDX_W-1:0] : cnt_r[PIDX_W-1:0];
  assign spd_a    = rear ? frame_r.w3 : frame_r.w1;
  assign spd_b    = rear ? frame_r.w4 : frame_r.w2;
  assign addr     = rear ? cfg.rear_address : cfg.front_address;
  assign spd_sel  = (pidx < POS_SPD_B) ? spd_a : spd_b;
  assign spd_off  = (pidx < POS_SPD_B) ? (pidx - POS_SPD_A) : (pidx - POS_SPD_B);

  // Pick the big-endian speed byte
  always_comb begin
    case (spd_off[1:0])
      2'd0:    spd_byte = spd_sel[31:24];
      2'd1:    spd_byte = spd_sel[23:16];
      2'd2:    spd_byte = spd_sel[15:8];
      default: spd_byte = spd_sel[7:0];
    endcase
  end

  always_comb begin
    case (pidx)
      POS_ADDR:  cur_byte = addr & BYTE_MASK;
      POS_CMD:   cur_byte = CMD_SPEED_PAIR;
      POS_CHECK: cur_byte = {1'b0, sum_r & CHECK_MASK};
      default:   cur_byte = spd_byte;
    endcase
  end

  // Take a new frame when idle or right after the final byte
  assign load = !q_stat.empty && (!busy_r || (advance && is_last));
  assign pop  = load;

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    tx_byte_nxt   = tx_byte_r;
    last_byte_nxt = last_byte_r;
    if (slot_free) begin
      out_valid_nxt = busy_r;
    end
    if (advance) begin
      tx_byte_nxt   = cur_byte;
      last_byte_nxt = is_last;
      sum_nxt       = (pidx == POS_ADDR) ? cur_byte[6:0] : sum_r + cur_byte[6:0];
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= q_data;
    end
    sum_r       <= sum_nxt;
    tx_byte_r   <= tx_byte_nxt;
    last_byte_r <= last_byte_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_last_byte = last_byte_r;

  `ASSERT_NEVER(a_pop_while_busy, pop && busy_r && !(advance && is_last))
  `ASSERT_CLK(a_last_is_check, out_valid_r && last_byte_r |-> !tx_byte_r[7])

endmodule

/* hw/rtl/mecanum_speed_command_framer_unit.sv */
// Mecanum speed command framer, top level: config registers, front end,
// frame queue and packet serializer. Uses msf_pkg and all msf_ modules.
//
// Each accepted command (func 0 forward, 1 rotation, 2 all three) updates
// the stored scaled velocities, mixes four wheel speeds and yields 22 bytes:
// a front packet (wheels 1 and 2) then a rear packet (wheels 3 and 4), each
// address, 37, two big-endian 32-bit speeds and a 7-bit checksum; the final
// byte carries out_last_byte. Func 3 is accepted and dropped. The front end
// takes one command per cycle while in_stall is low, through three register
// stages into a 4-frame queue, and a frame then passes the serializer frame
// and output registers. The serializer emits one byte per cycle while
// out_stall is low; in_stall rises once four frames are queued or in flight.
// Configuration writes are taken every cycle (cfg_ready is always high).
module mecanum_speed_command_framer_unit import msf_pkg::*; #(
  parameter int VEL_FRAC_BITS = VEL_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic signed [15:0] in_vel_forward,
  input  logic signed [15:0] in_vel_side,
  input  logic signed [15:0] in_vel_turn,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  logic    push;
  frame_t  push_data;
  logic    pop;
  frame_t  pop_data;

  assign cfg_ready = 1'b1;

  // Decode configuration writes; ignore indexes past the list
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINEAR_GAIN:   cfg_nxt.linear_gain       = cfg_wdata;
        CFG_ROTATION_GAIN: cfg_nxt.rotation_gain     = cfg_wdata;
        CFG_FRONT_ADDR:    cfg_nxt.front_address     = cfg_wdata[7:0];
        CFG_REAR_ADDR:     cfg_nxt.rear_address      = cfg_wdata[7:0];
        CFG_NEGATE_MASK:   cfg_nxt.wheel_negate_mask = cfg_wdata[3:0];
        CFG_INVERT_ROT:    cfg_nxt.invert_rotation   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.linear_gain       <= LINEAR_GAIN_RST;
      cfg_r.rotation_gain     <= ROTATION_GAIN_RST;
      cfg_r.front_address     <= FRONT_ADDR_RST;
      cfg_r.rear_address      <= REAR_ADDR_RST;
      cfg_r.wheel_negate_mask <= '0;
      cfg_r.invert_rotation   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  msf_front #(
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_vel_forward (in_vel_forward),
    .in_vel_side    (in_vel_side),
    .in_vel_turn    (in_vel_turn),
    .cfg            (cfg_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  msf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  msf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_stat        (q_stat),
    .q_data        (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

/* test/tb.sv */
// Self-checking testbench for the mecanum speed command framer.
// Depends on msf_pkg and mecanum_speed_command_framer_unit; checks each
// serial byte against a cycle-free predictor of the frame contents.
`timescale 1ns / 1ps

module tb import msf_pkg::*; ();

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]         func;
    logic signed [15:0] fwd;
    logic signed [15:0] side;
    logic signed [15:0] turn;
  } speed_cmd_t;

  typedef struct {
    logic [7:0] tx;
    logic       last;
  } wire_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = FUNC_FORWARD;
  logic signed [15:0] in_vel_forward = '0;
  logic signed [15:0] in_vel_side = '0;
  logic signed [15:0] in_vel_turn = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_tx_byte;
  logic out_last_byte;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_LINEAR_GAIN;
  logic [15:0] cfg_wdata = '0;

  // Shadow copy of the register file
  logic [15:0] lin_gain = LINEAR_GAIN_RST;
  logic [15:0] rot_gain = ROTATION_GAIN_RST;
  logic [7:0]  front_addr = FRONT_ADDR_RST;
  logic [7:0]  rear_addr = REAR_ADDR_RST;
  logic [3:0]  negate_mask = 4'd0;
  logic        invert_turn = 1'b0;

  // Stored scaled velocities
  longint fwd_scaled = 0;
  longint side_scaled = 0;
  longint turn_scaled = 0;

  speed_cmd_t cmd_pending_q[$];
  wire_byte_t tx_expect_q[$];
  speed_cmd_t cur_cmd;

  int send_idle_pct = 16;
  int recv_idle_pct = 76;
  int cmds_queued = 0;
  int cmds_taken = 0;
  int cmds_dropped = 0;
  int bytes_checked = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;
  int fail_cnt = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  mecanum_speed_command_framer_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_vel_forward(in_vel_forward),
    .in_vel_side   (in_vel_side),
    .in_vel_turn   (in_vel_turn),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Queue one 11-byte packet: address, command, two big-endian speeds, checksum
  task automatic queue_packet(input logic [7:0] addr, input logic [31:0] spd_a,
                              input logic [31:0] spd_b, input logic is_rear);
    logic [7:0] pk [11];
    logic [7:0] sum;
    wire_byte_t b;
    pk[0] = addr;
    pk[1] = CMD_SPEED_PAIR;
    for (int i = 0; i < 4; i++) begin
      pk[2 + i] = spd_a[31 - 8 * i -: 8];
      pk[6 + i] = spd_b[31 - 8 * i -: 8];
    end
    sum = '0;
    for (int i = 0; i < PKT_LEN - 1; i++) sum += pk[i];
    pk[PKT_LEN - 1] = sum & {1'b0, CHECK_MASK};
    for (int i = 0; i < PKT_LEN; i++) begin
      b.tx = pk[i];
      b.last = is_rear && (i == PKT_LEN - 1);
      tx_expect_q.push_back(b);
    end
  endtask

  // Update the stored velocities and queue the 22 bytes of one command, or count an unused one as dropped
  task automatic predict_frame(input speed_cmd_t c);
    longint turn_in;
    longint wheel [4];
    if (c.func == FUNC_UNUSED) begin
      cmds_dropped++;
      return;
    end
    turn_in = longint'(c.turn);
    if (invert_turn) turn_in = -turn_in;
    // Arithmetic shift on a signed product rounds toward minus infinity
    if (c.func == FUNC_FORWARD || c.func == FUNC_TWIST)
      fwd_scaled = (longint'(c.fwd) * longint'(lin_gain)) >>> VEL_FRAC_BITS_DEF;
    if (c.func == FUNC_TWIST)
      side_scaled = (longint'(c.side) * longint'(lin_gain)) >>> VEL_FRAC_BITS_DEF;
    if (c.func == FUNC_TURN || c.func == FUNC_TWIST)
      turn_scaled = (turn_in * longint'(rot_gain)) >>> VEL_FRAC_BITS_DEF;
    wheel[0] = fwd_scaled - side_scaled + turn_scaled;
    wheel[1] = fwd_scaled + side_scaled - turn_scaled;
    wheel[2] = fwd_scaled - side_scaled - turn_scaled;
    wheel[3] = fwd_scaled + side_scaled + turn_scaled;
    for (int i = 0; i < 4; i++)
      if (negate_mask[i]) wheel[i] = -wheel[i];
    queue_packet(front_addr, 32'(wheel[0]), 32'(wheel[1]), 1'b0);
    queue_packet(rear_addr, 32'(wheel[2]), 32'(wheel[3]), 1'b1);
  endtask

  // Command driver: hold the item while stalled, idle at random between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) stall_cycles++;
      if (in_valid && !in_stall) begin
        predict_frame(cur_cmd);
        cmds_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_pending_q.pop_front();
          in_func <= cur_cmd.func;
          in_vel_forward <= cur_cmd.fwd;
          in_vel_side <= cur_cmd.side;
          in_vel_turn <= cur_cmd.turn;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Byte receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // Byte monitor: compare each accepted byte with the oldest expectation
  always @(posedge clk) begin
    wire_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tx_expect_q.size() == 0) begin
        $error("unexpected byte: tx_byte %0h last_byte %0b", out_tx_byte, out_last_byte);
        fail_cnt++;
      end else begin
        want = tx_expect_q.pop_front();
        bytes_checked++;
        if (out_tx_byte !== want.tx) begin
          $error("tx_byte mismatch: expected %0h, actual %0h", want.tx, out_tx_byte);
          fail_cnt++;
        end
        if (out_last_byte !== want.last) begin
          $error("last_byte mismatch: expected %0b, actual %0b", want.last, out_last_byte);
          fail_cnt++;
        end
      end
    end
  end

  task automatic write_cfg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_LINEAR_GAIN:   lin_gain = val;
      CFG_ROTATION_GAIN: rot_gain = val;
      CFG_FRONT_ADDR:    front_addr = val[7:0];
      CFG_REAR_ADDR:     rear_addr = val[7:0];
      CFG_NEGATE_MASK:   negate_mask = val[3:0];
      CFG_INVERT_ROT:    invert_turn = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all_cfg(input logic [15:0] lg, input logic [15:0] rg,
                               input logic [7:0] fa, input logic [7:0] ra,
                               input logic [3:0] mask, input logic inv);
    write_cfg(CFG_LINEAR_GAIN, lg);
    write_cfg(CFG_ROTATION_GAIN, rg);
    write_cfg(CFG_FRONT_ADDR, {8'd0, fa});
    write_cfg(CFG_REAR_ADDR, {8'd0, ra});
    write_cfg(CFG_NEGATE_MASK, {12'd0, mask});
    write_cfg(CFG_INVERT_ROT, {15'd0, inv});
  endtask

  task automatic push_cmd(input logic [1:0] func, input logic [15:0] f,
                          input logic [15:0] s, input logic [15:0] t);
    speed_cmd_t c;
    c.func = func;
    c.fwd = f;
    c.side = s;
    c.turn = t;
    cmd_pending_q.push_back(c);
    cmds_queued++;
  endtask

  // Extremes, small magnitudes near zero, and full-range values
  function automatic logic [15:0] rand_vel();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(15));
      3: return -16'($urandom_range(16));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_random_cmds(input int n);
    logic [1:0] func;
    for (int i = 0; i < n; i++) begin
      func = ($urandom_range(99) < 8) ? FUNC_UNUSED : 2'($urandom_range(2));
      push_cmd(func, rand_vel(), rand_vel(), rand_vel());
    end
  endtask

  // Wait until every command is taken and every byte checked, then let the pipe drain
  task automatic drain_and_settle();
    while (cmds_taken != cmds_queued || tx_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands at reset settings
    push_cmd(FUNC_FORWARD, 16'h7FFF, 16'h0000, 16'h0000);
    push_cmd(FUNC_FORWARD, 16'h8000, 16'h1234, 16'h4321);
    push_cmd(FUNC_FORWARD, 16'hFFFF, 16'h0000, 16'h0000);
    push_cmd(FUNC_FORWARD, 16'h0001, 16'h0000, 16'h0000);
    push_cmd(FUNC_TURN, 16'h5A5A, 16'h0000, 16'h7FFF);
    push_cmd(FUNC_TURN, 16'h0000, 16'hFFFF, 16'h8000);
    push_cmd(FUNC_TURN, 16'h0000, 16'h0000, 16'hFFFF);
    push_cmd(FUNC_TWIST, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_cmd(FUNC_TWIST, 16'h8000, 16'h8000, 16'h8000);
    push_cmd(FUNC_TWIST, 16'h8000, 16'h7FFF, 16'hFFFF);
    // Unused function code must leave the stored velocities alone
    push_cmd(FUNC_UNUSED, 16'h3039, 16'hFFFF, 16'h8000);
    push_cmd(FUNC_FORWARD, 16'h0005, 16'hFFFF, 16'hFFFF);
    push_cmd(FUNC_TWIST, 16'h0001, 16'hFFFF, 16'h0100);
    push_cmd(FUNC_TWIST, 16'h5555, 16'hAAAA, 16'h00FF);
    push_cmd(FUNC_TWIST, 16'h0000, 16'h0000, 16'h0000);
    drain_and_settle();

    // Largest gains, all wheels negated, rotation inverted
    write_all_cfg(16'hFFFF, 16'hFFFF, 8'h00, 8'hFF, 4'hF, 1'b1);
    push_cmd(FUNC_TURN, 16'h0000, 16'h0000, 16'h8000);
    push_cmd(FUNC_TWIST, 16'h7FFF, 16'h8000, 16'h8000);
    push_cmd(FUNC_TWIST, 16'h8000, 16'h7FFF, 16'h7FFF);
    push_cmd(FUNC_UNUSED, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_cmd(FUNC_FORWARD, 16'h8000, 16'h0000, 16'h0000);
    push_cmd(FUNC_TURN, 16'h0000, 16'h0000, 16'hFFFF);
    push_random_cmds(40);
    drain_and_settle();

    // Zero gains, swapped address extremes
    write_all_cfg(16'h0000, 16'h0000, 8'hFF, 8'h00, 4'h0, 1'b0);
    push_random_cmds(30);
    drain_and_settle();

    // Random settings, sender idles most
    write_all_cfg(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                  4'($urandom), 1'($urandom));
    send_idle_pct <= 76;
    recv_idle_pct <= 16;
    push_random_cmds(50);
    drain_and_settle();

    // Random settings, no idling, long receiver hold-off to back up the input
    write_all_cfg(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                  4'($urandom), 1'($urandom));
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_go <= 1'b1;
    push_random_cmds(60);
    drain_and_settle();

    $display("Ran %0d commands (%0d with the unused code) over %0d register writes.",
             cmds_taken, cmds_dropped, cfg_writes);
    $display("Checked %0d serial bytes; input was held off for %0d cycles.",
             bytes_checked, stall_cycles);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(3_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/msf_pkg.sv
hw/rtl/msf_front.sv
hw/rtl/msf_queue.sv
hw/rtl/msf_back.sv
hw/rtl/mecanum_speed_command_framer_unit.sv
test/tb.sv
